>>> design/button_debounce_click_detector_defines.svh
// Assertion helpers for the click detector. They expect clk and arst_n in scope.
`ifndef BUTTON_DEBOUNCE_CLICK_DETECTOR_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDCD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("click detector check failed");

// The consequent must hold in the cycle after the antecedent.
`define BDCD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("click detector check failed");

`endif

>>> design/bdcd_pkg.sv
package bdcd_pkg;

	localparam int NUM_KEYS_DEF = 16;
	localparam int KEY_W = 16;
	localparam int KIDX_W = 4;
	localparam int EV_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TICK_W = 32;
	localparam int HOLD_W = 16;

	localparam logic [HOLD_W-1:0] HOLD_GUARD = 16'd65530;
	localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hffff;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANALYSE_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SCAN_DIVISOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS = 3'd5;

	localparam logic [7:0] SCAN_INTERVAL_RST = 8'd5;
	localparam logic [7:0] ANALYSE_INTERVAL_RST = 8'd60;
	localparam logic [7:0] IDLE_SCAN_DIVISOR_RST = 8'd6;
	localparam logic [7:0] DEBOUNCE_COUNT_RST = 8'd3;
	localparam logic [15:0] LONG_TICKS_RST = 16'd200;
	localparam logic [15:0] SHORT_TICKS_RST = 16'd60;

	// Key machine phases (low nibble of a key machine byte).
	localparam logic [3:0] PH_RELEASED = 4'd0;
	localparam logic [3:0] PH_PRESSED = 4'd1;
	localparam logic [3:0] PH_RELEASE_WAIT = 4'd2;
	localparam logic [3:0] PH_SECOND_PRESS = 4'd3;
	localparam logic [3:0] PH_LONG = 4'd5;

	typedef enum logic [EV_W-1:0] {
		EV_DOWN = 3'd0,
		EV_UP = 3'd1,
		EV_SINGLE = 3'd2,
		EV_DOUBLE = 3'd3,
		EV_LSTART = 3'd4,
		EV_LHOLD = 3'd5
	} ev_t;

	typedef struct packed {
		logic fresh;
		logic held;
		logic others;
	} key_cond_t;

	typedef struct packed {
		logic [7:0] machine;
		logic hit;
		ev_t ev;
	} key_step_t;

endpackage

>>> design/bdcd_ifs.sv
interface bdcd_tick_if import bdcd_pkg::*; ();
	logic valid;
	logic ready;
	logic [KEY_W-1:0] raw_keys;

	modport source (output valid, output raw_keys, input ready);
	modport sink (input valid, input raw_keys, output ready);
endinterface

interface bdcd_event_if import bdcd_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIDX_W-1:0] key_index;
	logic [EV_W-1:0] evt_code;

	modport source (output valid, output key_index, output evt_code, input ready);
	modport sink (input valid, input key_index, input evt_code, output ready);
endinterface

interface bdcd_cfg_if import bdcd_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/bdcd_rem_unit.sv
module bdcd_rem_unit import bdcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TICK_W-1:0] dividend,
	input  logic [7:0]        divisor,
	output logic              busy,
	output logic              done,
	output logic [7:0]        rem
);

	logic [TICK_W-1:0] num_q;
	logic [7:0] div_q;
	logic [7:0] rem_q;
	logic [2:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [8:0] trial;
	logic [7:0] rem_next;

	// Four restoring remainder steps per cycle, most significant bits first.
	always_comb begin
		rem_next = rem_q;
		trial = '0;
		for (int i = 0; i < 4; i++) begin
			trial = {rem_next, num_q[TICK_W-1-i]};
			if (trial >= {1'b0, div_q})
				trial = trial - {1'b0, div_q};
			rem_next = trial[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			div_q <= 8'd1;
			rem_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 3'd7);
			if (start) begin
				num_q <= dividend;
				// A divisor of zero behaves as one.
				div_q <= (divisor == 8'd0) ? 8'd1 : divisor;
				rem_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= rem_next;
				num_q <= num_q << 4;
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7)
					busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem = rem_q;

endmodule

>>> design/bdcd_key_step.sv
module bdcd_key_step import bdcd_pkg::*; (
	input  logic [7:0]        machine,
	input  key_cond_t         cond,
	input  logic [HOLD_W-1:0] hold_time,
	input  logic [15:0]       long_thresh,
	input  logic [15:0]       short_thresh,
	output key_step_t         result
);

	logic [3:0] phase;
	logic [3:0] count;
	logic [3:0] count_inc;

	always_comb begin
		// Another key's fresh press knocks this key back to released.
		phase = cond.others ? PH_RELEASED : machine[3:0];
		count = machine[7:4];
		count_inc = machine[7:4] + 4'd1;
		result.hit = 1'b0;
		result.ev = EV_DOWN;
		case (phase)
			PH_RELEASED: begin
				if (cond.fresh) begin
					result.hit = 1'b1;
					result.ev = EV_DOWN;
					count = 4'd1;
					phase = PH_PRESSED;
				end
			end
			PH_PRESSED: begin
				if (!cond.held) begin
					result.hit = 1'b1;
					result.ev = EV_UP;
					phase = PH_RELEASE_WAIT;
				end else if (hold_time > long_thresh) begin
					result.hit = 1'b1;
					result.ev = EV_LSTART;
					phase = PH_LONG;
				end
			end
			PH_RELEASE_WAIT: begin
				if (cond.fresh) begin
					result.hit = 1'b1;
					result.ev = EV_DOWN;
					count = count_inc;
					if (count_inc == 4'd2)
						phase = PH_SECOND_PRESS;
				end else if (hold_time > short_thresh) begin
					phase = PH_RELEASED;
					// Runs of three or more presses end silently.
					if (count == 4'd1) begin
						result.hit = 1'b1;
						result.ev = EV_SINGLE;
					end else if (count == 4'd2) begin
						result.hit = 1'b1;
						result.ev = EV_DOUBLE;
					end
				end
			end
			PH_SECOND_PRESS: begin
				if (!cond.held) begin
					result.hit = 1'b1;
					result.ev = EV_UP;
					phase = (hold_time < short_thresh) ? PH_RELEASE_WAIT : PH_RELEASED;
				end
			end
			PH_LONG: begin
				result.hit = 1'b1;
				if (cond.held) begin
					result.ev = EV_LHOLD;
				end else begin
					result.ev = EV_UP;
					phase = PH_RELEASED;
				end
			end
			default: begin
			end
		endcase
		result.machine = {count, phase};
	end

endmodule

>>> design/button_debounce_click_detector.sv
// Button debounce and click detector. Each transfer on tick carries one sample of up to
// sixteen raw key levels; the block debounces them every scan interval (thinned by the
// idle divisor while no change is pending) and, on scan ticks that fall on an analyse
// interval, walks the per-key machines and sends at most one event (down, up, single,
// double, long start, long hold) on key_evt. One shared remainder unit, four bits per
// cycle, computes every modulo the sequencer needs. Every tick takes one remainder; a scan
// tick adds one or two more, an analysis tick adds the idle check (no walk while no key
// is held and the hold count has reached the long threshold), a walk of up to NUM_KEYS
// keys, and the hand-over of a found event to the output register. tick is not ready
// while a tick is in progress. The event waits there for its transfer while a new tick is
// taken, unless a second event is ready first. Configuration writes are always taken.
`include "button_debounce_click_detector_defines.svh"

module button_debounce_click_detector import bdcd_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	bdcd_tick_if.sink   tick,
	bdcd_event_if.source key_evt,
	bdcd_cfg_if.sink    cfg
);

	localparam int KM_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAIT_SCAN,
		ST_WAIT_IDLE,
		ST_SCAN,
		ST_WAIT_ANA,
		ST_ANALYSE,
		ST_KEYS,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [7:0] scan_q;
	logic [7:0] ana_q;
	logic [7:0] idle_div_q;
	logic [7:0] dbc_q;
	logic [15:0] long_q;
	logic [15:0] short_q;

	logic [TICK_W-1:0] tick_q;
	logic [KEY_W-1:0] raw_q;
	logic [HOLD_W-1:0] hold_q;
	logic [KEY_W-1:0] stable_q;
	logic [KEY_W-1:0] cand_q;
	logic [7:0] eq_q;
	logic deb_q;
	logic [KEY_W-1:0] cur_q;
	logic [KEY_W-1:0] newp_q;
	logic [7:0] km_q [NUM_KEYS];
	logic [KIDX_W-1:0] k_q;
	ev_t pend_ev_q;

	logic out_valid_q;
	logic [KIDX_W-1:0] out_idx_q;
	ev_t out_ev_q;

	logic div_start;
	logic [TICK_W-1:0] div_dividend;
	logic [7:0] div_divisor;
	logic div_busy;
	logic div_done;
	logic [7:0] div_rem;

	logic [HOLD_W-1:0] hold_inc;
	logic [8:0] eq_inc;
	logic [KEY_W-1:0] key_bit;
	key_cond_t cond;
	key_step_t step;
	logic tick_xfer;

	assign tick.ready = (state_q == ST_IDLE);
	assign tick_xfer = tick.valid && tick.ready;
	assign cfg.ready = 1'b1;

	assign key_evt.valid = out_valid_q;
	assign key_evt.key_index = out_idx_q;
	assign key_evt.evt_code = out_ev_q;

	assign hold_inc = (hold_q == HOLD_MAX) ? hold_q : hold_q + 16'd1;
	assign eq_inc = {1'b0, eq_q} + 9'd1;

	assign key_bit = KEY_W'(1) << k_q;
	assign cond.fresh = newp_q[k_q] && cur_q[k_q];
	assign cond.held = cur_q[k_q];
	assign cond.others = (newp_q != '0) && (newp_q != key_bit);

	bdcd_key_step u_key_step (
		.machine      (km_q[k_q[KM_IDX_W-1:0]]),
		.cond         (cond),
		.hold_time    (hold_q),
		.long_thresh  (long_q),
		.short_thresh (short_q),
		.result       (step)
	);

	bdcd_rem_unit u_rem_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.rem      (div_rem)
	);

	// The remainder unit is shared between the scan, idle thinning and analyse checks.
	always_comb begin
		div_start = 1'b0;
		div_dividend = tick_q;
		div_divisor = ana_q;
		case (state_q)
			ST_IDLE: begin
				if (tick_xfer) begin
					div_start = 1'b1;
					div_dividend = tick_q + 32'd1;
					div_divisor = scan_q;
				end
			end
			ST_WAIT_SCAN: begin
				if (div_done && div_rem == 8'd0 && !deb_q) begin
					div_start = 1'b1;
					div_dividend = {16'd0, hold_inc};
					div_divisor = idle_div_q;
				end
			end
			ST_WAIT_IDLE: begin
				if (div_done && div_rem != 8'd0)
					div_start = 1'b1;
			end
			ST_SCAN: begin
				div_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= SCAN_INTERVAL_RST;
			ana_q <= ANALYSE_INTERVAL_RST;
			idle_div_q <= IDLE_SCAN_DIVISOR_RST;
			dbc_q <= DEBOUNCE_COUNT_RST;
			long_q <= LONG_TICKS_RST;
			short_q <= SHORT_TICKS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SCAN_INTERVAL:     scan_q <= cfg.data[7:0];
				CFG_ANALYSE_INTERVAL:  ana_q <= cfg.data[7:0];
				CFG_IDLE_SCAN_DIVISOR: idle_div_q <= cfg.data[7:0];
				CFG_DEBOUNCE_COUNT:    dbc_q <= cfg.data[7:0];
				CFG_LONG_TICKS:        long_q <= cfg.data;
				CFG_SHORT_TICKS:       short_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_q <= '0;
			raw_q <= '0;
			hold_q <= '0;
			stable_q <= '0;
			cand_q <= '0;
			eq_q <= '0;
			deb_q <= 1'b0;
			cur_q <= '0;
			newp_q <= '0;
			for (int i = 0; i < NUM_KEYS; i++)
				km_q[i] <= '0;
			k_q <= '0;
			pend_ev_q <= EV_DOWN;
			out_valid_q <= 1'b0;
			out_idx_q <= '0;
			out_ev_q <= EV_DOWN;
		end else begin
			if (state_q == ST_EMIT && (!out_valid_q || key_evt.ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && key_evt.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (tick_xfer) begin
						tick_q <= tick_q + 32'd1;
						raw_q <= tick.raw_keys;
						state_q <= ST_WAIT_SCAN;
					end
				end
				ST_WAIT_SCAN: begin
					if (div_done) begin
						if (div_rem != 8'd0) begin
							state_q <= ST_IDLE;
						end else begin
							hold_q <= hold_inc;
							state_q <= deb_q ? ST_SCAN : ST_WAIT_IDLE;
						end
					end
				end
				ST_WAIT_IDLE: begin
					// Off the thinned scans the sample is skipped, the analyse check is not.
					if (div_done)
						state_q <= (div_rem == 8'd0) ? ST_SCAN : ST_WAIT_ANA;
				end
				ST_SCAN: begin
					if (raw_q != stable_q) begin
						if (raw_q != cand_q) begin
							deb_q <= 1'b1;
							eq_q <= '0;
							cand_q <= raw_q;
						end else if (eq_inc >= {1'b0, dbc_q}) begin
							stable_q <= raw_q;
							eq_q <= '0;
							hold_q <= 16'd1;
							deb_q <= 1'b0;
						end else begin
							deb_q <= 1'b1;
							eq_q <= eq_inc[7:0];
						end
					end else begin
						eq_q <= '0;
						cand_q <= raw_q;
					end
					state_q <= ST_WAIT_ANA;
				end
				ST_WAIT_ANA: begin
					if (div_done)
						state_q <= (div_rem == 8'd0) ? ST_ANALYSE : ST_IDLE;
				end
				ST_ANALYSE: begin
					if (hold_q >= long_q && cur_q == '0) begin
						if (hold_q > HOLD_GUARD)
							hold_q <= long_q;
						state_q <= ST_IDLE;
					end else begin
						newp_q <= stable_q & (stable_q ^ cur_q);
						cur_q <= stable_q;
						k_q <= '0;
						state_q <= ST_KEYS;
					end
				end
				ST_KEYS: begin
					km_q[k_q[KM_IDX_W-1:0]] <= step.machine;
					if (step.hit) begin
						pend_ev_q <= step.ev;
						state_q <= ST_EMIT;
					end else if (k_q == KIDX_W'(NUM_KEYS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || key_evt.ready) begin
						out_idx_q <= k_q;
						out_ev_q <= pend_ev_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`BDCD_ASSERT_SAME(a_div_not_restarted, div_start, !div_busy)
	`BDCD_ASSERT_SAME(a_key_walk_in_range, state_q == ST_KEYS, {1'b0, k_q} < (KIDX_W+1)'(NUM_KEYS))
	`BDCD_ASSERT_SAME(a_accept_restarts_hold, $fell(deb_q), hold_q == 16'd1)
	`BDCD_ASSERT_NEXT(a_emit_leaves_result, state_q == ST_EMIT && !out_valid_q, out_valid_q)

endmodule
